// ===== design/srs_pkg.sv =====
// Package for the selective repeat sender: item structs, operation and
// frame kind codes, window limits and the shared add/subtract request type.
// No dependencies.
`default_nettype none

package srs_pkg;

  localparam int CNT_W = 6;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_ACK     = 3'd2;
  localparam logic [2:0] OP_TIMEOUT = 3'd3;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FIN  = 1'b1;

  localparam logic [3:0] WIN_RESET = 4'd3;
  localparam logic [3:0] WIN_MIN   = 4'd1;
  localparam logic [3:0] WIN_MAX   = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] message_byte;
    logic       final_byte;
    logic [5:0] requested_frame;
  } in_item_t;

  typedef struct packed {
    logic       frame_kind;
    logic [4:0] frame_number;
    logic [7:0] frame_payload;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic             sub;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  function automatic logic [3:0] burst_len(logic [3:0] w);
    logic [3:0] r;
    if (w == 4'd0) r = WIN_MIN;
    else if (w > WIN_MAX) r = WIN_MAX;
    else r = w;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/srs_addsub.sv =====
// Shared 6-bit add/subtract unit with carry/borrow out.
// Depends on srs_pkg.
`default_nettype none

module srs_addsub (
  input  srs_pkg::alu_req_t         req_i,
  output logic [srs_pkg::CNT_W:0]   res_o
);
  import srs_pkg::*;

  always_comb begin
    if (req_i.sub) begin
      res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
  end

endmodule

`default_nettype wire

// ===== design/srs_msg_mem.sv =====
// Message byte store: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module srs_msg_mem #(
  parameter int MSG_DEPTH = 32,
  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [MSG_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/srs_ctrl.sv =====
// Sequencer of the sender: link state, window counting and frame issue.
// Depends on srs_pkg; drives srs_msg_mem and the shared srs_addsub unit.
`default_nettype none

module srs_ctrl #(
  parameter int MSG_DEPTH = 32,
  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  srs_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output srs_pkg::out_item_t          out_item_o,
  output srs_pkg::alu_req_t           alu_req_o,
  input  logic [srs_pkg::CNT_W:0]     alu_res_i,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [7:0]                  mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [7:0]                  mem_rdata_i
);
  import srs_pkg::*;

  localparam int CAP = (MSG_DEPTH < 63) ? MSG_DEPTH : 63;
  localparam logic [CNT_W-1:0] CAP_LEN = CNT_W'(CAP);

  typedef enum logic [1:0] {ST_IDLE, ST_COUNT, ST_ISSUE, ST_WRITE} state_e;
  typedef enum logic [1:0] {PH_RESEND, PH_BURST, PH_FIN} phase_e;

  state_e           state_q;
  phase_e           phase_q;
  logic [2:0]       op_q;
  logic [3:0]       win_q;
  logic [CNT_W-1:0] length_q, acked_q, sent_q, from_q, resend_num_q;
  logic             active_q, closed_q;
  logic             resend_q, fin_q;
  logic [3:0]       cnt_q, idx_q;
  logic             pend_kind_q, pend_last_q;
  logic [4:0]       pend_num_q;
  logic             out_valid_q;
  out_item_t        out_item_q;

  logic             accept;
  logic [CNT_W-1:0] len_eff, rem, num;
  logic [3:0]       lim, cnt_calc;
  logic             fin_calc, last_calc, slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign len_eff     = closed_q ? '0 : length_q;
  assign mem_we_o    = accept && (in_item_i.operation == OP_LOAD) && !active_q
                       && (len_eff < CAP_LEN);
  assign mem_waddr_o = AW'(len_eff);
  assign mem_wdata_o = in_item_i.message_byte;

  always_comb begin
    alu_req_o.sub = (state_q == ST_COUNT);
    alu_req_o.a   = alu_req_o.sub ? length_q : from_q;
    alu_req_o.b   = alu_req_o.sub ? from_q : {2'b00, idx_q};
  end

  always_comb begin
    rem      = alu_res_i[CNT_W] ? '0 : alu_res_i[CNT_W-1:0];
    lim      = (op_q == OP_ACK) ? WIN_MIN : burst_len(win_q);
    cnt_calc = (rem < {2'b00, lim}) ? rem[3:0] : lim;
    unique case (op_q)
      OP_START: fin_calc = (cnt_calc == 4'd0);
      OP_ACK:   fin_calc = (cnt_calc != 4'd0) ? (acked_q > sent_q) : (acked_q >= sent_q);
      default:  fin_calc = 1'b0;
    endcase
  end

  always_comb begin
    unique case (phase_q)
      PH_RESEND: begin
        num       = resend_num_q;
        last_calc = (cnt_q == 4'd0) && !fin_q;
      end
      PH_BURST: begin
        num       = alu_res_i[CNT_W-1:0];
        last_calc = (idx_q == cnt_q - 4'd1) && !fin_q;
      end
      default: begin
        num       = '0;
        last_calc = 1'b1;
      end
    endcase
  end

  assign mem_re_o    = (state_q == ST_ISSUE) && (phase_q != PH_FIN);
  assign mem_raddr_o = AW'(num);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_FIN;
      op_q         <= OP_LOAD;
      win_q        <= WIN_RESET;
      length_q     <= '0;
      acked_q      <= '0;
      sent_q       <= '0;
      from_q       <= '0;
      resend_num_q <= '0;
      active_q     <= 1'b0;
      closed_q     <= 1'b0;
      resend_q     <= 1'b0;
      fin_q        <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      pend_kind_q  <= KIND_DATA;
      pend_last_q  <= 1'b0;
      pend_num_q   <= '0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (out_ready_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= in_item_i.operation;
            resend_q <= 1'b0;
            unique case (in_item_i.operation)
              OP_LOAD: begin
                if (!active_q) begin
                  length_q <= (len_eff < CAP_LEN) ? len_eff + 6'd1 : len_eff;
                  closed_q <= in_item_i.final_byte;
                end
              end
              OP_START: begin
                if (!active_q) begin
                  from_q  <= '0;
                  state_q <= ST_COUNT;
                end
              end
              OP_ACK: begin
                if (active_q) begin
                  acked_q      <= acked_q + 6'd1;
                  from_q       <= sent_q;
                  resend_q     <= (in_item_i.requested_frame < sent_q);
                  resend_num_q <= in_item_i.requested_frame;
                  state_q      <= ST_COUNT;
                end
              end
              OP_TIMEOUT: begin
                if (active_q) begin
                  from_q  <= acked_q;
                  state_q <= ST_COUNT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_COUNT: begin
          cnt_q <= cnt_calc;
          fin_q <= fin_calc;
          idx_q <= '0;
          if (op_q == OP_START) begin
            closed_q <= 1'b1;
            acked_q  <= '0;
            sent_q   <= {2'b00, cnt_calc};
            active_q <= (cnt_calc != 4'd0);
          end else if (op_q == OP_ACK) begin
            sent_q   <= sent_q + {5'b0, (cnt_calc != 4'd0)};
            active_q <= !fin_calc;
          end
          priority if (resend_q) begin
            phase_q <= PH_RESEND;
            state_q <= ST_ISSUE;
          end else if (cnt_calc != 4'd0) begin
            phase_q <= PH_BURST;
            state_q <= ST_ISSUE;
          end else if (fin_calc) begin
            phase_q <= PH_FIN;
            state_q <= ST_ISSUE;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          pend_kind_q <= (phase_q == PH_FIN) ? KIND_FIN : KIND_DATA;
          pend_num_q  <= num[4:0];
          pend_last_q <= last_calc;
          state_q     <= ST_WRITE;
        end
        ST_WRITE: begin
          if (slot_free) begin
            out_valid_q              <= 1'b1;
            out_item_q.frame_kind    <= pend_kind_q;
            out_item_q.frame_number  <= pend_num_q;
            out_item_q.frame_payload <= (pend_kind_q == KIND_FIN) ? 8'd0 : mem_rdata_i;
            out_item_q.run_end       <= pend_last_q;
            if (pend_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_ISSUE;
              unique case (phase_q)
                PH_RESEND: phase_q <= (cnt_q != 4'd0) ? PH_BURST : PH_FIN;
                PH_BURST: begin
                  if (idx_q + 4'd1 < cnt_q) begin
                    idx_q <= idx_q + 4'd1;
                  end else begin
                    phase_q <= PH_FIN;
                  end
                end
                default: phase_q <= PH_FIN;
              endcase
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/selective_repeat_sender.sv =====
// Selective repeat ARQ sender, top level.
// Depends on srs_pkg, srs_addsub, srs_msg_mem and srs_ctrl.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one event per item:
//   load byte, start, ack, timeout or an ignored frame. Output channel
//   (out_valid_o/out_ready_i/out_item_o) gives data and FIN frames; run_end
//   marks the last frame caused by one input item.
//   cfg_we_i/cfg_wdata_i write the window size in any cycle the link is idle.
// Item handling:
//   Load and ignored items are taken while the sequencer stays idle. Start,
//   ack and timeout first size the burst with the shared add/subtract unit,
//   then issue each frame by a message store read, then an output register
//   load. in_ready_o is low while an item is in work.
// Reset: window size 3, message empty, link idle, no frame pending.
// Receiver stall: the sequencer waits on the output register and resumes
//   when out_ready_i takes the frame; nothing is dropped.
`default_nettype none

module selective_repeat_sender #(
  parameter int MSG_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srs_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srs_pkg::out_item_t out_item_o
);
  import srs_pkg::*;

  localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

  alu_req_t        alu_req;
  logic [CNT_W:0]  alu_res;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata, mem_rdata;

  srs_addsub u_addsub (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  srs_msg_mem #(.MSG_DEPTH(MSG_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srs_ctrl #(.MSG_DEPTH(MSG_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.frame_kind == KIND_FIN) |->
      (out_item_o.frame_number == 5'd0) && (out_item_o.frame_payload == 8'd0))
    else $error("FIN frame with nonzero number or payload");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.frame_kind == KIND_FIN) |-> out_item_o.run_end)
    else $error("FIN frame not marked as run end");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.operation == OP_LOAD) |=> in_ready_o)
    else $error("load item left the sender busy");

endmodule

`default_nettype wire

// ===== tb/selective_repeat_sender_tb.sv =====
// Self-checking testbench for selective_repeat_sender: directed and random
// event items, a predictor of the emitted frames, random idling on both sides.
// Depends on srs_pkg and the selective_repeat_sender RTL.
`timescale 1ns / 1ps

module selective_repeat_sender_tb;
  import srs_pkg::*;

  localparam int MSG_DEPTH = 32;
  localparam logic [2:0] OP_OTHER = 3'd4;
  localparam logic [2:0] OP_TOP   = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOKED} rx_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  selective_repeat_sender #(.MSG_DEPTH(MSG_DEPTH)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // sender-side model state
  logic [7:0]  msg_mem [MSG_DEPTH];
  int unsigned msg_len    = 0;
  int unsigned ack_cnt    = 0;
  int unsigned sent_cnt   = 0;
  bit          xfer_on    = 1'b0;
  bit          msg_sealed = 1'b0;
  logic [3:0]  win_reg    = WIN_RESET;

  in_item_t  pending_items[$];
  out_item_t frames_due[$];
  int        n_queued = 0;
  int        n_taken  = 0;
  int        errors   = 0;

  logic      in_acc     = 1'b0;
  int        gap_left   = 0;
  int        burst_left = 0;
  rx_mode_e  rx_mode    = RX_OPEN;
  int        rx_left    = 0;

  function automatic void emit(logic kind, logic [5:0] num);
    out_item_t f;
    f.frame_kind    = kind;
    f.frame_number  = (kind == KIND_FIN) ? 5'd0 : num[4:0];
    f.frame_payload = (kind == KIND_FIN || num >= MSG_DEPTH) ? 8'd0 : msg_mem[num];
    f.run_end       = 1'b0;
    frames_due.push_back(f);
  endfunction

  function automatic void predict_frames(in_item_t it);
    int unsigned n0;
    int unsigned wmax;
    int unsigned i;
    out_item_t   f;
    n0   = frames_due.size();
    wmax = (win_reg == 4'd0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
    case (it.operation)
      OP_LOAD: begin
        if (!xfer_on) begin
          if (msg_sealed) msg_len = 0;
          if (msg_len < MSG_DEPTH) begin
            msg_mem[msg_len] = it.message_byte;
            msg_len++;
          end
          msg_sealed = it.final_byte;
        end
      end
      OP_START: begin
        if (!xfer_on) begin
          msg_sealed = 1'b1;
          ack_cnt    = 0;
          i          = 0;
          while (i < wmax && i < msg_len) begin
            emit(KIND_DATA, 6'(i));
            i++;
          end
          sent_cnt = i;
          if (i == 0) emit(KIND_FIN, 6'd0);
          else xfer_on = 1'b1;
        end
      end
      OP_ACK: begin
        if (xfer_on) begin
          ack_cnt = (ack_cnt + 1) & 63;
          if (it.requested_frame < sent_cnt) emit(KIND_DATA, it.requested_frame);
          if (sent_cnt < msg_len) begin
            emit(KIND_DATA, 6'(sent_cnt));
            sent_cnt++;
          end
          if (ack_cnt >= sent_cnt) begin
            emit(KIND_FIN, 6'd0);
            xfer_on = 1'b0;
          end
        end
      end
      OP_TIMEOUT: begin
        if (xfer_on) begin
          i = 0;
          while (i < wmax && ack_cnt + i < msg_len) begin
            emit(KIND_DATA, 6'(ack_cnt + i));
            i++;
          end
        end
      end
      default: ;
    endcase
    if (frames_due.size() > n0) begin
      f = frames_due.pop_back();
      f.run_end = 1'b1;
      frames_due.push_back(f);
    end
  endfunction

  // check frames, then account for the item taken at this edge
  always @(posedge clk_i) begin : mon
    out_item_t want;
    if (rst_ni) begin
      in_acc <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected frame kind=%0d num=%0d data=%02h end=%0d",
                     out_item_o.frame_kind, out_item_o.frame_number,
                     out_item_o.frame_payload, out_item_o.run_end);
        end else begin
          want = frames_due.pop_front();
          if (want !== out_item_o) begin
            errors++;
            if (errors <= 10)
              $display({"frame mismatch: exp kind=%0d num=%0d data=%02h end=%0d,",
                        " got kind=%0d num=%0d data=%02h end=%0d"},
                       want.frame_kind, want.frame_number, want.frame_payload,
                       want.run_end, out_item_o.frame_kind, out_item_o.frame_number,
                       out_item_o.frame_payload, out_item_o.run_end);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_frames(in_item_i);
        n_taken++;
      end
    end
  end

  // item driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_acc)) begin
      if (gap_left != 0 || pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
          gap_left   <= $urandom_range(0, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // frame sink: stall pattern changes every stretch
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:   out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic push_op(logic [2:0] op, logic [7:0] b, logic fb, logic [5:0] req);
    in_item_t it;
    it.operation       = op;
    it.message_byte    = b;
    it.final_byte      = fb;
    it.requested_frame = req;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // wait until every item is taken and every frame seen; close any open transfer
  task automatic settle();
    bit more;
    more = 1'b1;
    while (more) begin
      do @(negedge clk_i); while (n_taken != n_queued || frames_due.size() != 0);
      do @(negedge clk_i); while (!in_ready_o);
      repeat (8) @(negedge clk_i);
      if (xfer_on) push_op(OP_ACK, 8'd0, 1'b0, 6'd63);
      else more = 1'b0;
    end
  endtask

  task automatic set_window(logic [3:0] w);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    win_reg      = w;
  endtask

  task automatic gen_transfer(inout int budget);
    int unsigned len;
    int unsigned steps;
    int unsigned k;
    int unsigned r;
    logic        fb;
    r   = $urandom_range(0, 19);
    len = (r == 0) ? $urandom_range(28, 40) : $urandom_range(1, 10);
    for (k = 0; k < len; k++) begin
      fb = (k == len - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 40) == 0);
      push_op(OP_LOAD, 8'($urandom), fb, 6'($urandom));
    end
    push_op(OP_START, 8'($urandom), 1'($urandom), 6'($urandom));
    steps = len + $urandom_range(0, 3);
    for (k = 0; k < steps; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        push_op(OP_ACK, 8'($urandom), 1'($urandom), 6'($urandom_range(0, len + 1)));
      else if (r < 65)
        push_op(OP_ACK, 8'($urandom), 1'($urandom), 6'($urandom_range(0, 63)));
      else if (r < 85)
        push_op(OP_TIMEOUT, 8'($urandom), 1'($urandom), 6'($urandom));
      else if (r < 92)
        push_op(3'($urandom_range(OP_OTHER, OP_TOP)), 8'($urandom), 1'($urandom),
                6'($urandom));
      else if (r < 96)
        push_op(OP_LOAD, 8'($urandom), 1'($urandom), 6'($urandom));
      else
        push_op(OP_START, 8'($urandom), 1'($urandom), 6'($urandom));
    end
    budget -= len + 1 + steps;
  endtask

  initial begin
    int budget;
    int ph;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty start, idle events, extremes, resend cases, reuse
    push_op(OP_START,   8'h00, 1'b0, 6'd0);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd0);
    push_op(OP_TIMEOUT, 8'h00, 1'b0, 6'd0);
    push_op(OP_LOAD,    8'h00, 1'b0, 6'd0);
    push_op(OP_LOAD,    8'hFF, 1'b0, 6'd63);
    push_op(OP_LOAD,    8'hA5, 1'b0, 6'd0);
    push_op(OP_LOAD,    8'h5A, 1'b1, 6'd0);
    push_op(OP_OTHER,   8'hFF, 1'b1, 6'd63);
    push_op(OP_TOP,     8'h00, 1'b0, 6'd0);
    push_op(OP_START,   8'h00, 1'b0, 6'd0);
    push_op(OP_LOAD,    8'h11, 1'b1, 6'd0);
    push_op(OP_START,   8'h00, 1'b0, 6'd0);
    push_op(OP_TIMEOUT, 8'h00, 1'b0, 6'd0);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd1);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd63);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd4);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd0);
    push_op(OP_LOAD,    8'h42, 1'b1, 6'd0);
    push_op(OP_START,   8'h00, 1'b0, 6'd0);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd0);
    push_op(OP_START,   8'h00, 1'b0, 6'd0);
    push_op(OP_TIMEOUT, 8'h00, 1'b0, 6'd0);
    push_op(OP_ACK,     8'h00, 1'b0, 6'd32);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_window(WIN_MIN);
        2: set_window(WIN_MAX);
        3: set_window(4'd0);
        4: set_window(4'd15);
        5: set_window(4'($urandom_range(2, 7)));
        default: ;
      endcase
      budget = 48;
      while (budget > 0) gen_transfer(budget);
      settle();
    end

    repeat (30) @(negedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
